// ===== sv/apsl_pkg.sv =====
// ----------------------------------------------------------------------------
// apsl_pkg
// Shared types and constants of the actuator PWM slew limiter.
// ----------------------------------------------------------------------------
`default_nettype none

package apsl_pkg;

   localparam int LEVEL_W    = 12;
   localparam int FULL_SCALE = 2048;
   localparam int POINT_W    = 12;
   localparam int TABLE_W    = 60;
   localparam int PCT_W      = 13;
   localparam int PCT_ONE    = 4096;
   localparam int FRAC_W     = 12;
   localparam int TICK_W     = 32;
   localparam int FS_W       = 16;
   localparam int ARR_W      = 16;
   localparam int CMP_W      = 17;
   localparam int PROD_W     = 26;
   localparam int CMP_PROD_W = 29;
   localparam int LEVEL_SHIFT = 11;
   localparam int DIVIDEND_W = TICK_W + LEVEL_SHIFT;
   localparam int DIV_CNT_W  = $clog2(DIVIDEND_W);
   localparam int CSR_DATA_W = 64;
   localparam int CSR_ADDR_W = 6;

   localparam logic [2:0] REG_LEFT_PUMP_TABLE  = 3'd0;
   localparam logic [2:0] REG_LEFT_FAN_TABLE   = 3'd1;
   localparam logic [2:0] REG_RIGHT_PUMP_TABLE = 3'd2;
   localparam logic [2:0] REG_RIGHT_FAN_TABLE  = 3'd3;
   localparam logic [2:0] REG_RISE_FULL_SCALE  = 3'd4;
   localparam logic [2:0] REG_FALL_FULL_SCALE  = 3'd5;
   localparam logic [2:0] REG_FAN_INVERTED     = 3'd6;
   localparam logic [2:0] REG_AUTO_RELOAD      = 3'd7;

   localparam logic CMD_SET   = 1'b0;
   localparam logic CMD_START = 1'b1;

   localparam logic STATUS_OK      = 1'b0;
   localparam logic STATUS_INVALID = 1'b1;

   localparam logic [1:0] ACT_LEFT_PUMP  = 2'd0;
   localparam logic [1:0] ACT_LEFT_FAN   = 2'd1;
   localparam logic [1:0] ACT_RIGHT_PUMP = 2'd2;

   localparam int OP_W = 4;
   localparam logic [OP_W-1:0] OP_NONE        = 4'd0;
   localparam logic [OP_W-1:0] OP_LATCH       = 4'd1;
   localparam logic [OP_W-1:0] OP_CLEAR       = 4'd2;
   localparam logic [OP_W-1:0] OP_INTERP      = 4'd3;
   localparam logic [OP_W-1:0] OP_TARGET      = 4'd4;
   localparam logic [OP_W-1:0] OP_SETUP       = 4'd5;
   localparam logic [OP_W-1:0] OP_DIV_STEP    = 4'd6;
   localparam logic [OP_W-1:0] OP_APPLY       = 4'd7;
   localparam logic [OP_W-1:0] OP_MUL         = 4'd8;
   localparam logic [OP_W-1:0] OP_OUT_SET     = 4'd9;
   localparam logic [OP_W-1:0] OP_OUT_INVALID = 4'd10;
   localparam logic [OP_W-1:0] OP_NEXT        = 4'd11;

   typedef struct packed {
      logic                command;
      logic [2:0]          channel;
      logic signed [15:0]  percentage;
      logic [TICK_W-1:0]   tick;
   } apsl_req_type;

   typedef struct packed {
      logic [1:0]         actuator;
      logic [2:0]         timer_channel;
      logic [CMP_W-1:0]   compare_value;
      logic [LEVEL_W-1:0] applied_level;
      logic               status;
      logic               last;
   } apsl_rsp_type;

   typedef struct packed {
      logic [TABLE_W-1:0] left_pump_table;
      logic [TABLE_W-1:0] left_fan_table;
      logic [TABLE_W-1:0] right_pump_table;
      logic [TABLE_W-1:0] right_fan_table;
      logic [FS_W-1:0]    rise_full_scale_ms;
      logic [FS_W-1:0]    fall_full_scale_ms;
      logic               fan_inverted;
      logic [ARR_W-1:0]   auto_reload;
   } apsl_cfg_type;

   typedef struct packed {
      logic [OP_W-1:0] op;
   } apsl_cmd_type;

   typedef struct packed {
      logic start;
      logic invalid;
      logic last_item;
      logic fs_zero;
      logic div_done;
      logic rsp_busy;
   } apsl_stat_type;

   function automatic logic [2:0] timer_channel_of(input logic [1:0] act);
      logic [2:0] tc;
      case (act)
         ACT_LEFT_PUMP:  tc = 3'd3;
         ACT_LEFT_FAN:   tc = 3'd4;
         ACT_RIGHT_PUMP: tc = 3'd2;
         default:        tc = 3'd1;
      endcase
      return tc;
   endfunction

endpackage

`default_nettype wire

// ===== sv/actuator_pwm_slew_limiter.sv =====
// ----------------------------------------------------------------------------
// actuator_pwm_slew_limiter
// Slew-limited PWM compare generator for two pumps and two fans.
// ----------------------------------------------------------------------------
// Requests arrive on req_valid/req_ready with a command, channel, Q12
// percentage and millisecond tick. Results leave on rsp_valid/rsp_ready, one
// per set request and one per channel for a start request; last marks the
// final result of a request. Tables, slew times, fan inversion and the timer
// reload value are written through the APB-style port at byte address 8*i.
// A set request runs through table interpolation and target clamping, a
// setup step, a one-bit-per-cycle divider that forms the slew step, then an
// apply, a multiply and an output step. With a slew time of zero the divider
// takes no steps and the level moves straight to the target. A start request
// runs that sequence once per channel. An invalid channel goes straight to
// its result.
// One request is worked on at a time; the next is accepted the cycle after
// the final result is loaded. A stalled receiver holds the result register,
// and the sequence waits for it to empty before loading the next result.
// Reset clears all levels and tick stamps, the tables and slew times to zero
// and the reload to 65535.
// ----------------------------------------------------------------------------
`default_nettype none

module actuator_pwm_slew_limiter
   import apsl_pkg::*;
#(
   parameter int LEVEL_POINTS = 5,
   parameter int CHANNELS     = 4
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  apsl_req_type          req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output apsl_rsp_type          rsp_data,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   apsl_cfg_type  cfg;
   apsl_cmd_type  cmd;
   apsl_stat_type stat;

   apsl_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   apsl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   apsl_datapath #(
      .LEVEL_POINTS (LEVEL_POINTS),
      .CHANNELS     (CHANNELS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .cmd       (cmd),
      .req_data  (req_data),
      .stat      (stat),
      .rsp_data  (rsp_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready)
   );

endmodule

`default_nettype wire

// ===== sv/apsl_csr.sv =====
// ----------------------------------------------------------------------------
// apsl_csr
// APB-style register file holding the level tables, slew times, fan
// inversion and timer reload value.
// ----------------------------------------------------------------------------
`default_nettype none

module apsl_csr
   import apsl_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output apsl_cfg_type          cfg
);

   apsl_cfg_type cfg_ff;
   apsl_cfg_type cfg_in;
   logic         wr_en;
   logic [2:0]   reg_idx;

   assign wr_en   = psel & penable & pwrite;
   assign reg_idx = paddr[CSR_ADDR_W-1:3];
   assign pready  = 1'b1;
   assign cfg     = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_LEFT_PUMP_TABLE:  cfg_in.left_pump_table    = pwdata[TABLE_W-1:0];
            REG_LEFT_FAN_TABLE:   cfg_in.left_fan_table     = pwdata[TABLE_W-1:0];
            REG_RIGHT_PUMP_TABLE: cfg_in.right_pump_table   = pwdata[TABLE_W-1:0];
            REG_RIGHT_FAN_TABLE:  cfg_in.right_fan_table    = pwdata[TABLE_W-1:0];
            REG_RISE_FULL_SCALE:  cfg_in.rise_full_scale_ms = pwdata[FS_W-1:0];
            REG_FALL_FULL_SCALE:  cfg_in.fall_full_scale_ms = pwdata[FS_W-1:0];
            REG_FAN_INVERTED:     cfg_in.fan_inverted       = pwdata[0];
            REG_AUTO_RELOAD:      cfg_in.auto_reload        = pwdata[ARR_W-1:0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_LEFT_PUMP_TABLE:  prdata = CSR_DATA_W'(cfg_ff.left_pump_table);
         REG_LEFT_FAN_TABLE:   prdata = CSR_DATA_W'(cfg_ff.left_fan_table);
         REG_RIGHT_PUMP_TABLE: prdata = CSR_DATA_W'(cfg_ff.right_pump_table);
         REG_RIGHT_FAN_TABLE:  prdata = CSR_DATA_W'(cfg_ff.right_fan_table);
         REG_RISE_FULL_SCALE:  prdata = CSR_DATA_W'(cfg_ff.rise_full_scale_ms);
         REG_FALL_FULL_SCALE:  prdata = CSR_DATA_W'(cfg_ff.fall_full_scale_ms);
         REG_FAN_INVERTED:     prdata = CSR_DATA_W'(cfg_ff.fan_inverted);
         REG_AUTO_RELOAD:      prdata = CSR_DATA_W'(cfg_ff.auto_reload);
         default:              prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{left_pump_table:    '0,
                     left_fan_table:     '0,
                     right_pump_table:   '0,
                     right_fan_table:    '0,
                     rise_full_scale_ms: '0,
                     fall_full_scale_ms: '0,
                     fan_inverted:       1'b0,
                     auto_reload:        '1};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

// ===== sv/apsl_datapath.sv =====
// ----------------------------------------------------------------------------
// apsl_datapath
// Level interpolation, serial slew divider, compare multiplier, per-channel
// state and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module apsl_datapath
   import apsl_pkg::*;
#(
   parameter int LEVEL_POINTS = 5,
   parameter int CHANNELS     = 4
)
(
   input  logic          clock,
   input  logic          reset,
   input  apsl_cfg_type  cfg,
   input  apsl_cmd_type  cmd,
   input  apsl_req_type  req_data,
   output apsl_stat_type stat,
   output apsl_rsp_type  rsp_data,
   output logic          rsp_valid,
   input  logic          rsp_ready
);

   localparam int POS_W    = $clog2(PCT_ONE * (LEVEL_POINTS - 1) + 1);
   localparam int IDX_W    = $clog2(LEVEL_POINTS);
   localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   logic                     start_ff, start_in;
   logic                     invalid_ff, invalid_in;
   logic [1:0]               ch_ff, ch_in;
   logic [PCT_W-1:0]         pct_ff, pct_in;
   logic [TICK_W-1:0]        tick_ff, tick_in;
   logic [POINT_W-1:0]       lo_ff, lo_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic [LEVEL_W-1:0]       target_ff, target_in;
   logic [FS_W-1:0]          fs_ff, fs_in;
   logic [FS_W-1:0]          rem_ff, rem_in;
   logic [DIVIDEND_W-1:0]    quot_ff, quot_in;
   logic [DIV_CNT_W-1:0]     div_cnt_ff, div_cnt_in;
   logic [LEVEL_W-1:0]       duty_ff, duty_in;
   logic [CMP_PROD_W-1:0]    cmp_prod_ff, cmp_prod_in;
   logic [LEVEL_W-1:0]       level_ff [CHANNELS];
   logic [LEVEL_W-1:0]       level_in [CHANNELS];
   logic [TICK_W-1:0]        stamp_ff [CHANNELS];
   logic [TICK_W-1:0]        stamp_in [CHANNELS];
   apsl_rsp_type             rsp_ff, rsp_in;
   logic                     rsp_valid_ff, rsp_valid_in;

   logic [CH_IDX_W-1:0]      ch_idx;
   logic [TABLE_W-1:0]       table_sel;
   logic [POINT_W-1:0]       pts [LEVEL_POINTS];
   logic [POS_W-1:0]         pos;
   logic [IDX_W-1:0]         lower;
   logic [IDX_W-1:0]         upper;
   logic signed [POINT_W:0]  span;
   logic signed [PROD_W-1:0] num;
   logic [LEVEL_W-1:0]       level_cur;
   logic [TICK_W-1:0]        elapsed;
   logic [FS_W:0]            shifted;
   logic                     fits;
   logic [LEVEL_W-1:0]       gap;
   logic [LEVEL_W-1:0]       level_new;
   logic [CMP_W-1:0]         arr_p1;
   logic [CMP_PROD_W-1:0]    cmp_sum;
   logic                     last_item;

   assign ch_idx    = ch_ff[CH_IDX_W-1:0];
   assign level_cur = level_ff[ch_idx];
   assign elapsed   = tick_ff - stamp_ff[ch_idx];
   assign last_item = !start_ff || (ch_ff == 2'(CHANNELS - 1));
   assign arr_p1    = {1'b0, cfg.auto_reload} + 17'd1;
   assign cmp_sum   = cmp_prod_ff + 29'd1024;

   always_comb begin
      case (ch_ff)
         ACT_LEFT_PUMP:  table_sel = cfg.left_pump_table;
         ACT_LEFT_FAN:   table_sel = cfg.left_fan_table;
         ACT_RIGHT_PUMP: table_sel = cfg.right_pump_table;
         default:        table_sel = cfg.right_fan_table;
      endcase
   end

   always_comb begin
      for (int k = 0; k < LEVEL_POINTS; k++) begin
         pts[k] = table_sel[k*POINT_W +: POINT_W];
         if (pts[k] > 12'(FULL_SCALE)) begin
            pts[k] = 12'(FULL_SCALE);
         end
      end
   end

   always_comb begin
      pos   = POS_W'(pct_ff) * POS_W'(LEVEL_POINTS - 1);
      lower = IDX_W'(pos >> FRAC_W);
      if (lower == IDX_W'(LEVEL_POINTS - 1)) begin
         upper = lower;
      end else begin
         upper = lower + IDX_W'(1);
      end
      span = $signed({1'b0, pts[upper]}) - $signed({1'b0, pts[lower]});
      num  = $signed({2'b00, lo_ff, 12'h000}) + prod_ff + 26'sd2048;
   end

   always_comb begin
      shifted = {rem_ff, quot_ff[DIVIDEND_W-1]};
      fits    = shifted >= {1'b0, fs_ff};
   end

   always_comb begin
      if (target_ff > level_cur) begin
         gap = target_ff - level_cur;
      end else begin
         gap = level_cur - target_ff;
      end
      if (fs_ff == '0) begin
         level_new = target_ff;
      end else if (target_ff > level_cur && DIVIDEND_W'(gap) > quot_ff) begin
         level_new = level_cur + quot_ff[LEVEL_W-1:0];
      end else if (target_ff < level_cur && DIVIDEND_W'(gap) > quot_ff) begin
         level_new = level_cur - quot_ff[LEVEL_W-1:0];
      end else begin
         level_new = target_ff;
      end
   end

   always_comb begin
      start_in     = start_ff;
      invalid_in   = invalid_ff;
      ch_in        = ch_ff;
      pct_in       = pct_ff;
      tick_in      = tick_ff;
      lo_in        = lo_ff;
      prod_in      = prod_ff;
      target_in    = target_ff;
      fs_in        = fs_ff;
      rem_in       = rem_ff;
      quot_in      = quot_ff;
      div_cnt_in   = div_cnt_ff;
      duty_in      = duty_ff;
      cmp_prod_in  = cmp_prod_ff;
      level_in     = level_ff;
      stamp_in     = stamp_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (cmd.op)
         OP_LATCH: begin
            start_in   = req_data.command == CMD_START;
            invalid_in = req_data.channel >= 3'(CHANNELS);
            ch_in      = req_data.channel[1:0];
            tick_in    = req_data.tick;
            if (req_data.percentage[15]) begin
               pct_in = '0;
            end else if (req_data.percentage > 16'sd4096) begin
               pct_in = PCT_W'(PCT_ONE);
            end else begin
               pct_in = req_data.percentage[PCT_W-1:0];
            end
         end
         OP_CLEAR: begin
            ch_in  = '0;
            pct_in = '0;
            for (int c = 0; c < CHANNELS; c++) begin
               level_in[c] = '0;
               stamp_in[c] = tick_ff;
            end
         end
         OP_INTERP: begin
            lo_in   = pts[lower];
            prod_in = $signed({1'b0, pos[FRAC_W-1:0]}) * span;
         end
         OP_TARGET: begin
            if (num[PROD_W-1]) begin
               target_in = '0;
            end else if (num[PROD_W-1:FRAC_W] > 14'(FULL_SCALE)) begin
               target_in = 12'(FULL_SCALE);
            end else begin
               target_in = num[FRAC_W+LEVEL_W-1:FRAC_W];
            end
         end
         OP_SETUP: begin
            if (target_ff >= level_cur) begin
               fs_in = cfg.rise_full_scale_ms;
            end else begin
               fs_in = cfg.fall_full_scale_ms;
            end
            quot_in    = {elapsed, 11'b0};
            rem_in     = '0;
            div_cnt_in = '0;
         end
         OP_DIV_STEP: begin
            if (fits) begin
               rem_in = FS_W'(shifted - {1'b0, fs_ff});
            end else begin
               rem_in = shifted[FS_W-1:0];
            end
            quot_in    = {quot_ff[DIVIDEND_W-2:0], fits};
            div_cnt_in = div_cnt_ff + DIV_CNT_W'(1);
         end
         OP_APPLY: begin
            level_in[ch_idx] = level_new;
            stamp_in[ch_idx] = tick_ff;
            if (cfg.fan_inverted && ch_ff[0]) begin
               duty_in = 12'(FULL_SCALE) - level_new;
            end else begin
               duty_in = level_new;
            end
         end
         OP_MUL: begin
            cmp_prod_in = {17'b0, duty_ff} * {12'b0, arr_p1};
         end
         OP_OUT_SET: begin
            rsp_in.actuator      = ch_ff;
            rsp_in.timer_channel = timer_channel_of(ch_ff);
            rsp_in.compare_value = cmp_sum[CMP_W+LEVEL_SHIFT-1:LEVEL_SHIFT];
            rsp_in.applied_level = level_cur;
            rsp_in.status        = STATUS_OK;
            rsp_in.last          = last_item;
            rsp_valid_in         = 1'b1;
         end
         OP_OUT_INVALID: begin
            rsp_in        = '0;
            rsp_in.status = STATUS_INVALID;
            rsp_in.last   = 1'b1;
            rsp_valid_in  = 1'b1;
         end
         OP_NEXT: begin
            ch_in = ch_ff + 2'd1;
         end
         default: begin
            ch_in = ch_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      start_ff    <= start_in;
      invalid_ff  <= invalid_in;
      ch_ff       <= ch_in;
      pct_ff      <= pct_in;
      tick_ff     <= tick_in;
      lo_ff       <= lo_in;
      prod_ff     <= prod_in;
      target_ff   <= target_in;
      fs_ff       <= fs_in;
      rem_ff      <= rem_in;
      quot_ff     <= quot_in;
      div_cnt_ff  <= div_cnt_in;
      duty_ff     <= duty_in;
      cmp_prod_ff <= cmp_prod_in;
      rsp_ff      <= rsp_in;
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         for (int c = 0; c < CHANNELS; c++) begin
            level_ff[c] <= '0;
            stamp_ff[c] <= '0;
         end
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         level_ff     <= level_in;
         stamp_ff     <= stamp_in;
      end
   end

   assign stat.start     = start_ff;
   assign stat.invalid   = invalid_ff;
   assign stat.last_item = last_item;
   assign stat.fs_zero   = fs_ff == '0;
   assign stat.div_done  = div_cnt_ff == DIV_CNT_W'(DIVIDEND_W - 1);
   assign stat.rsp_busy  = rsp_valid_ff;
   assign rsp_data       = rsp_ff;
   assign rsp_valid      = rsp_valid_ff;

`ifndef SYNTH
   a_load_only_when_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_OUT_SET || cmd.op == OP_OUT_INVALID) |-> !rsp_valid_ff)
      else $error("result register loaded while a result is pending");

   a_result_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.applied_level <= 12'(FULL_SCALE)
                        && rsp_ff.compare_value <= 17'h10000))
      else $error("result level or compare value out of range");
`endif

endmodule

`default_nettype wire

// ===== sv/apsl_ctrl.sv =====
// ----------------------------------------------------------------------------
// apsl_ctrl
// Sequencer that steps the datapath through latch, interpolation, slew
// division, compare scaling and result hand-off for each channel.
// ----------------------------------------------------------------------------
`default_nettype none

module apsl_ctrl
   import apsl_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  apsl_stat_type stat,
   output apsl_cmd_type  cmd
);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_DECIDE = 4'd1;
   localparam logic [3:0] S_INVAL  = 4'd2;
   localparam logic [3:0] S_INTERP = 4'd3;
   localparam logic [3:0] S_TARGET = 4'd4;
   localparam logic [3:0] S_SETUP  = 4'd5;
   localparam logic [3:0] S_DIV    = 4'd6;
   localparam logic [3:0] S_APPLY  = 4'd7;
   localparam logic [3:0] S_MUL    = 4'd8;
   localparam logic [3:0] S_OUT    = 4'd9;
   localparam logic [3:0] S_NEXT   = 4'd10;

   logic [3:0] state_ff, state_in;

   assign req_ready = state_ff == S_IDLE;

   always_comb begin
      state_in = state_ff;
      cmd.op   = OP_NONE;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.op   = OP_LATCH;
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (stat.start) begin
               cmd.op   = OP_CLEAR;
               state_in = S_INTERP;
            end else if (stat.invalid) begin
               state_in = S_INVAL;
            end else begin
               cmd.op   = OP_INTERP;
               state_in = S_TARGET;
            end
         end
         S_INVAL: begin
            if (!stat.rsp_busy) begin
               cmd.op   = OP_OUT_INVALID;
               state_in = S_IDLE;
            end
         end
         S_INTERP: begin
            cmd.op   = OP_INTERP;
            state_in = S_TARGET;
         end
         S_TARGET: begin
            cmd.op   = OP_TARGET;
            state_in = S_SETUP;
         end
         S_SETUP: begin
            cmd.op   = OP_SETUP;
            state_in = S_DIV;
         end
         S_DIV: begin
            if (stat.fs_zero) begin
               state_in = S_APPLY;
            end else begin
               cmd.op = OP_DIV_STEP;
               if (stat.div_done) begin
                  state_in = S_APPLY;
               end
            end
         end
         S_APPLY: begin
            cmd.op   = OP_APPLY;
            state_in = S_MUL;
         end
         S_MUL: begin
            cmd.op   = OP_MUL;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!stat.rsp_busy) begin
               cmd.op = OP_OUT_SET;
               if (stat.last_item) begin
                  state_in = S_IDLE;
               end else begin
                  state_in = S_NEXT;
               end
            end
         end
         S_NEXT: begin
            cmd.op   = OP_NEXT;
            state_in = S_INTERP;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef SYNTH
   a_one_request_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted while another is in progress");

   a_last_result_frees_input: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT && !stat.rsp_busy && stat.last_item) |=> req_ready)
      else $error("input not reopened after the final result");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/tb_actuator_pwm_slew_limiter.sv =====
// ----------------------------------------------------------------------------
// tb_actuator_pwm_slew_limiter
// Self-checking testbench for the actuator PWM slew limiter.
// ----------------------------------------------------------------------------
// Directed requests cover the reset settings, table interpolation with
// clamped points, rise and fall slew limits with tick wrap, invalid channels
// and the start command. Random traffic follows under several register
// settings, extremes among them, and a long receiver hold-off fills the block.
// A predictor tracks levels, tick stamps and registers and checks each result.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_actuator_pwm_slew_limiter;
   import apsl_pkg::*;

   localparam int N_ACT         = 4;
   localparam int N_POINTS      = 5;
   localparam int N_REGS        = 8;
   localparam int CLOCK_HALF    = 4;
   localparam int RESET_CYCLES  = 10;
   localparam int SETTLE_CYCLES = 8;
   localparam int TAIL_CYCLES   = 64;
   localparam int LONG_HOLD     = 400;
   localparam int CYCLE_LIMIT   = 600000;
   localparam int PRINT_LIMIT   = 30;
   localparam int PHASES        = 5;
   localparam int PHASE_ITEMS   = 56;
   localparam int FLOOD_ITEMS   = 12;

   typedef enum logic [1:0] {RX_ALWAYS, RX_HALF, RX_QUARTER, RX_MOSTLY} rx_mode_type;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   apsl_req_type          req_data;
   logic                  rsp_valid;
   logic                  rsp_ready;
   apsl_rsp_type          rsp_data;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   apsl_cfg_type   model_cfg;
   int             level_now [N_ACT];
   logic [31:0]    stamp_ms [N_ACT];
   apsl_rsp_type   pending_results [$];
   logic [31:0]    clock_ms = 32'd0;

   int requests_sent    = 0;
   int start_requests   = 0;
   int invalid_requests = 0;
   int results_checked  = 0;
   int settings_written = 0;
   int mismatch_count   = 0;
   int hold_requests    = 0;
   int holds_served     = 0;
   int hold_left        = 0;
   int rx_mode_left     = 0;
   int cycle_count      = 0;
   rx_mode_type rx_mode = RX_ALWAYS;

   actuator_pwm_slew_limiter #(
      .LEVEL_POINTS(N_POINTS),
      .CHANNELS(N_ACT)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   function automatic logic [TABLE_W-1:0] pack_points(input int p0, input int p1,
                                                      input int p2, input int p3,
                                                      input int p4);
      return {POINT_W'(p4), POINT_W'(p3), POINT_W'(p2), POINT_W'(p1), POINT_W'(p0)};
   endfunction

   function automatic int clamped_point(input logic [TABLE_W-1:0] tab, input int idx);
      logic [POINT_W-1:0] p;
      p = tab[idx*POINT_W +: POINT_W];
      if (p > FULL_SCALE) return FULL_SCALE;
      return p;
   endfunction

   function automatic int target_level(input int ch, input int pct);
      logic [TABLE_W-1:0] tab;
      int pos, lower, upper, frac, lo, hi, num;
      case (ch[1:0])
         ACT_LEFT_PUMP:  tab = model_cfg.left_pump_table;
         ACT_LEFT_FAN:   tab = model_cfg.left_fan_table;
         ACT_RIGHT_PUMP: tab = model_cfg.right_pump_table;
         default:        tab = model_cfg.right_fan_table;
      endcase
      pos = pct * (N_POINTS - 1);
      lower = pos >> FRAC_W;
      if (lower > N_POINTS - 1) lower = N_POINTS - 1;
      upper = (lower < N_POINTS - 1) ? lower + 1 : lower;
      frac = pos - (lower << FRAC_W);
      lo = clamped_point(tab, lower);
      hi = clamped_point(tab, upper);
      num = lo * PCT_ONE + frac * (hi - lo) + PCT_ONE / 2;
      if (num < 0) num = 0;
      num = num >> FRAC_W;
      return (num > FULL_SCALE) ? FULL_SCALE : num;
   endfunction

   function automatic int slew_toward(input int ch, input int target, input logic [31:0] tick);
      logic [31:0]     elapsed;
      logic [FS_W-1:0] fs;
      logic [63:0]     step_size;
      int              lvl;
      elapsed = tick - stamp_ms[ch];
      lvl = level_now[ch];
      fs = (target >= lvl) ? model_cfg.rise_full_scale_ms : model_cfg.fall_full_scale_ms;
      stamp_ms[ch] = tick;
      if (fs == 0) begin
         lvl = target;
      end else begin
         step_size = ({32'd0, elapsed} << LEVEL_SHIFT) / {48'd0, fs};
         if (target > lvl && step_size < target - lvl) begin
            lvl = lvl + step_size[LEVEL_W-1:0];
         end else if (target < lvl && step_size < lvl - target) begin
            lvl = lvl - step_size[LEVEL_W-1:0];
         end else begin
            lvl = target;
         end
      end
      level_now[ch] = lvl;
      return lvl;
   endfunction

   function automatic logic [2:0] timer_slot(input logic [1:0] act);
      case (act)
         ACT_LEFT_PUMP:  return 3'd3;
         ACT_LEFT_FAN:   return 3'd4;
         ACT_RIGHT_PUMP: return 3'd2;
         default:        return 3'd1;
      endcase
   endfunction

   function automatic apsl_rsp_type drive_actuator(input int ch, input int pct,
                                                   input logic [31:0] tick, input logic last_one);
      apsl_rsp_type r;
      int           lvl, duty;
      logic [63:0]  product;
      lvl = slew_toward(ch, target_level(ch, pct), tick);
      duty = lvl;
      if (ch[0] && model_cfg.fan_inverted) duty = FULL_SCALE - lvl;
      product = 64'(duty);
      product = product * ({48'd0, model_cfg.auto_reload} + 64'd1) + FULL_SCALE / 2;
      r = '0;
      r.actuator      = ch[1:0];
      r.timer_channel = timer_slot(ch[1:0]);
      r.compare_value = product[LEVEL_SHIFT +: CMP_W];
      r.applied_level = lvl[LEVEL_W-1:0];
      r.status        = STATUS_OK;
      r.last          = last_one;
      return r;
   endfunction

   task automatic predict_actuator_results(input apsl_req_type r);
      int           ch, pct;
      apsl_rsp_type bad;
      if (r.command == CMD_START) begin
         start_requests++;
         for (ch = 0; ch < N_ACT; ch++) begin
            level_now[ch] = 0;
            stamp_ms[ch] = r.tick;
            pending_results.push_back(drive_actuator(ch, 0, r.tick, ch == N_ACT - 1));
         end
      end else if (r.channel >= N_ACT) begin
         invalid_requests++;
         bad = '0;
         bad.status = STATUS_INVALID;
         bad.last = 1'b1;
         pending_results.push_back(bad);
      end else begin
         pct = $signed(r.percentage);
         if (pct < 0) begin
            pct = 0;
         end else if (pct > PCT_ONE) begin
            pct = PCT_ONE;
         end
         pending_results.push_back(drive_actuator(r.channel, pct, r.tick, 1'b1));
      end
   endtask

   function automatic apsl_req_type make_req(input logic cmd, input int ch, input int pct,
                                             input logic [31:0] tick);
      apsl_req_type r;
      r.command    = cmd;
      r.channel    = 3'(ch);
      r.percentage = 16'(pct);
      r.tick       = tick;
      return r;
   endfunction

   function automatic logic [TABLE_W-1:0] random_table();
      logic [TABLE_W-1:0] tab;
      logic [POINT_W-1:0] p;
      int                 i;
      for (i = 0; i < N_POINTS; i++) begin
         case ($urandom_range(0, 9))
            0:       p = '0;
            1:       p = POINT_W'(FULL_SCALE);
            2:       p = POINT_W'($urandom_range(FULL_SCALE + 1, 4095));
            default: p = POINT_W'($urandom_range(0, FULL_SCALE));
         endcase
         tab[i*POINT_W +: POINT_W] = p;
      end
      return tab;
   endfunction

   function automatic logic [FS_W-1:0] random_full_scale();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return 16'd1;
         2:       return 16'hFFFF;
         3, 4, 5: return FS_W'($urandom_range(2, 300));
         default: return FS_W'($urandom_range(301, 20000));
      endcase
   endfunction

   function automatic apsl_cfg_type random_settings();
      apsl_cfg_type c;
      c.left_pump_table    = random_table();
      c.left_fan_table     = random_table();
      c.right_pump_table   = random_table();
      c.right_fan_table    = random_table();
      c.rise_full_scale_ms = random_full_scale();
      c.fall_full_scale_ms = random_full_scale();
      c.fan_inverted       = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 3))
         0:       c.auto_reload = '0;
         1:       c.auto_reload = 16'hFFFF;
         default: c.auto_reload = ARR_W'($urandom);
      endcase
      return c;
   endfunction

   function automatic apsl_req_type random_request();
      apsl_req_type r;
      int           pick;
      pick = $urandom_range(0, 19);
      if (pick >= 2 && pick <= 11) begin
         clock_ms = clock_ms + $urandom_range(1, 30);
      end else if (pick >= 12 && pick <= 16) begin
         clock_ms = clock_ms + $urandom_range(31, 3000);
      end else if (pick >= 17 && pick <= 18) begin
         clock_ms = clock_ms + $urandom_range(0, 1 << 20);
      end else if (pick == 19) begin
         clock_ms = $urandom;
      end
      r.tick = clock_ms;
      r.command = ($urandom_range(0, 15) == 0) ? CMD_START : CMD_SET;
      r.channel = 3'(($urandom_range(0, 9) == 0) ? $urandom_range(4, 7)
                                                  : $urandom_range(0, 3));
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
         r.percentage = 16'($urandom_range(0, PCT_ONE));
      end else if (pick < 9) begin
         r.percentage = 16'($urandom);
      end else begin
         case ($urandom_range(0, 5))
            0:       r.percentage = 16'sh8000;
            1:       r.percentage = 16'sh7FFF;
            2:       r.percentage = 16'(PCT_ONE);
            3:       r.percentage = 16'(PCT_ONE + 1);
            4:       r.percentage = '0;
            default: r.percentage = -16'sd1;
         endcase
      end
      return r;
   endfunction

   task automatic report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= PRINT_LIMIT) $display("MISMATCH: %s", what);
   endtask

   task automatic check_field(input string name, input int got, input int want);
      if (got != want) begin
         report_mismatch($sformatf("result %0d field %s: got %0d, expected %0d",
                                   results_checked, name, got, want));
      end
   endtask

   task automatic check_result(input apsl_rsp_type got);
      apsl_rsp_type want;
      if (pending_results.size() == 0) begin
         report_mismatch($sformatf("result %0d arrived with nothing expected",
                                   results_checked));
      end else begin
         want = pending_results.pop_front();
         check_field("actuator", got.actuator, want.actuator);
         check_field("timer_channel", got.timer_channel, want.timer_channel);
         check_field("compare_value", got.compare_value, want.compare_value);
         check_field("applied_level", got.applied_level, want.applied_level);
         check_field("status", got.status, want.status);
         check_field("last", got.last, want.last);
      end
      results_checked++;
   endtask

   task automatic send_request(input apsl_req_type r);
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
      requests_sent++;
      predict_actuator_results(r);
   endtask

   task automatic idle_for(input int cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic wait_for_drain();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_settings(input apsl_cfg_type c);
      logic [CSR_DATA_W-1:0] word [N_REGS];
      logic [CSR_DATA_W-1:0] pad;
      logic [2:0]            idx;
      int                    i;
      pad = {$urandom, $urandom};
      word[REG_LEFT_PUMP_TABLE]  = {pad[63:60], c.left_pump_table};
      word[REG_LEFT_FAN_TABLE]   = {pad[63:60], c.left_fan_table};
      word[REG_RIGHT_PUMP_TABLE] = {pad[63:60], c.right_pump_table};
      word[REG_RIGHT_FAN_TABLE]  = {pad[63:60], c.right_fan_table};
      word[REG_RISE_FULL_SCALE]  = {pad[63:16], c.rise_full_scale_ms};
      word[REG_FALL_FULL_SCALE]  = {pad[63:16], c.fall_full_scale_ms};
      word[REG_FAN_INVERTED]     = {pad[63:1], c.fan_inverted};
      word[REG_AUTO_RELOAD]      = {pad[63:16], c.auto_reload};
      for (i = 0; i < N_REGS; i++) begin
         idx = 3'(i);
         psel    <= 1'b1;
         penable <= 1'b0;
         pwrite  <= 1'b1;
         paddr   <= {idx, 3'b000};
         pwdata  <= word[idx];
         @(posedge clock);
         penable <= 1'b1;
         @(posedge clock);
      end
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      model_cfg = c;
      settings_written++;
   endtask

   task automatic test_reset_defaults();
      send_request(make_req(CMD_SET, 0, PCT_ONE, 32'd5));
      send_request(make_req(CMD_START, 3, 0, 32'd100));
      send_request(make_req(CMD_SET, 4, 2048, 32'd120));
      wait_for_drain();
   endtask

   task automatic test_interpolation();
      apsl_cfg_type c;
      c = model_cfg;
      c.left_pump_table    = pack_points(0, 512, 1024, 1536, 2048);
      c.left_fan_table     = pack_points(2048, 1536, 1024, 512, 0);
      c.right_pump_table   = pack_points(100, 4095, 3000, 7, 2049);
      c.right_fan_table    = pack_points(1, 4095, 0, 2047, 2048);
      c.rise_full_scale_ms = '0;
      c.fall_full_scale_ms = '0;
      c.fan_inverted       = 1'b1;
      c.auto_reload        = 16'd999;
      write_settings(c);
      send_request(make_req(CMD_SET, 0, PCT_ONE, 32'd200));
      send_request(make_req(CMD_SET, 0, 1, 32'd201));
      send_request(make_req(CMD_SET, 1, 2048, 32'd202));
      send_request(make_req(CMD_SET, 2, 1024, 32'd203));
      send_request(make_req(CMD_SET, 2, 1536, 32'd204));
      send_request(make_req(CMD_SET, 3, PCT_ONE + 1, 32'd205));
      send_request(make_req(CMD_SET, 3, -32768, 32'd206));
      send_request(make_req(CMD_SET, 0, 32767, 32'd207));
      send_request(make_req(CMD_SET, 1, -1, 32'd208));
      send_request(make_req(CMD_SET, 2, PCT_ONE - 1, 32'd209));
      wait_for_drain();
   endtask

   task automatic test_slew_limits();
      apsl_cfg_type c;
      c = model_cfg;
      c.rise_full_scale_ms = 16'd1000;
      c.fall_full_scale_ms = 16'hFFFF;
      c.fan_inverted       = 1'b0;
      c.auto_reload        = 16'hFFFF;
      write_settings(c);
      send_request(make_req(CMD_SET, 0, PCT_ONE, 32'd300));
      send_request(make_req(CMD_SET, 0, PCT_ONE, 32'd300));
      send_request(make_req(CMD_SET, 0, PCT_ONE, 32'd10300));
      send_request(make_req(CMD_SET, 0, 0, 32'd10301));
      send_request(make_req(CMD_SET, 2, 2048, 32'hFFFF_FFF0));
      send_request(make_req(CMD_SET, 2, 0, 32'h0000_0010));
      wait_for_drain();
      c.rise_full_scale_ms = 16'd1;
      c.fall_full_scale_ms = '0;
      write_settings(c);
      send_request(make_req(CMD_SET, 1, PCT_ONE, 32'd11));
      send_request(make_req(CMD_SET, 1, 0, 32'd11));
      wait_for_drain();
   endtask

   task automatic test_invalid_channels();
      send_request(make_req(CMD_SET, 5, $urandom_range(0, PCT_ONE), 32'd400));
      send_request(make_req(CMD_SET, 6, -32768, 32'd401));
      send_request(make_req(CMD_SET, 7, 32767, 32'hFFFF_FFFF));
      wait_for_drain();
   endtask

   task automatic test_start_command();
      apsl_cfg_type c;
      c = model_cfg;
      c.rise_full_scale_ms = 16'd1000;
      write_settings(c);
      send_request(make_req(CMD_START, 7, -1, 32'hFFFF_FFFF));
      wait_for_drain();
      clock_ms = 32'hFFFF_FFFF;
   endtask

   task automatic test_random_traffic();
      apsl_cfg_type c;
      int           phase, sent, burst, gap;
      for (phase = 0; phase < PHASES; phase++) begin
         c = random_settings();
         if (phase == 0) begin
            c.left_pump_table    = '1;
            c.right_pump_table   = '1;
            c.rise_full_scale_ms = 16'd1;
            c.fall_full_scale_ms = 16'd1;
            c.fan_inverted       = 1'b1;
            c.auto_reload        = 16'hFFFF;
         end else if (phase == 1) begin
            c.rise_full_scale_ms = 16'hFFFF;
            c.fall_full_scale_ms = 16'hFFFF;
            c.fan_inverted       = 1'b0;
            c.auto_reload        = '0;
         end
         write_settings(c);
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            burst = $urandom_range(1, 8);
            while (burst > 0 && sent < PHASE_ITEMS) begin
               send_request(random_request());
               sent++;
               burst--;
            end
            if ($urandom_range(0, 11) == 0) begin
               wait_for_drain();
            end else begin
               case ($urandom_range(0, 3))
                  0:       gap = 0;
                  1:       gap = $urandom_range(1, 8);
                  2:       gap = $urandom_range(9, 60);
                  default: gap = $urandom_range(61, 150);
               endcase
               if (gap > 0) idle_for(gap);
            end
         end
         wait_for_drain();
      end
   endtask

   task automatic test_backpressure();
      int k;
      hold_requests++;
      for (k = 0; k < FLOOD_ITEMS; k++) send_request(random_request());
      wait_for_drain();
   endtask

   initial begin
      clock = 1'b0;
      forever #CLOCK_HALF clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) check_result(rsp_data);
   end

   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (holds_served != hold_requests) begin
         holds_served++;
         hold_left = LONG_HOLD - 1;
         rsp_ready <= 1'b0;
      end else begin
         if (rx_mode_left == 0) begin
            rx_mode = rx_mode_type'($urandom_range(0, 3));
            rx_mode_left = $urandom_range(16, 96);
         end else begin
            rx_mode_left--;
         end
         case (rx_mode)
            RX_ALWAYS:  rsp_ready <= 1'b1;
            RX_HALF:    rsp_ready <= 1'($urandom_range(0, 1));
            RX_QUARTER: rsp_ready <= ($urandom_range(0, 3) == 0);
            default:    rsp_ready <= ($urandom_range(0, 7) != 0);
         endcase
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Timeout after %0d cycles with %0d results outstanding.",
               cycle_count, pending_results.size());
      $display("Some tests failed");
      $finish;
   end

   initial begin
      int ch;
      model_cfg = '0;
      model_cfg.auto_reload = 16'hFFFF;
      for (ch = 0; ch < N_ACT; ch++) begin
         level_now[ch] = 0;
         stamp_ms[ch] = '0;
      end
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      rsp_ready <= 1'b0;
      psel      <= 1'b0;
      penable   <= 1'b0;
      pwrite    <= 1'b0;
      paddr     <= '0;
      pwdata    <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_interpolation();
      test_slew_limits();
      test_invalid_channels();
      test_start_command();
      test_random_traffic();
      test_backpressure();

      wait_for_drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("Sent %0d requests (%0d start, %0d invalid channel) under %0d register settings.",
               requests_sent, start_requests, invalid_requests, settings_written);
      $display("Checked %0d results, %0d mismatches.", results_checked, mismatch_count);
      if (mismatch_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ===== files.f =====
sv/apsl_pkg.sv
sv/apsl_csr.sv
sv/apsl_datapath.sv
sv/apsl_ctrl.sv
sv/actuator_pwm_slew_limiter.sv
tb/sv/tb_actuator_pwm_slew_limiter.sv
